// File: src/rhh_pkg.sv
package rhh_pkg;

    localparam int RHH_SLOTS  = 1024;
    localparam int RHH_IDX_W  = $clog2(RHH_SLOTS);
    localparam int RHH_CNT_W  = 11;
    localparam int RHH_MAX_W  = 10;
    localparam int RHH_ADDR_W = 3;

    localparam logic [RHH_MAX_W-1:0] RHH_MAX_RESET = 10'd768;

    localparam logic [63:0] RHH_MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] RHH_MIX_C2 = 64'h94d049bb133111eb;
    localparam logic [63:0] RHH_HASH_ONE = 64'd1;

    localparam logic [2:0] RHH_HASH_MID  = 3'd2;
    localparam logic [2:0] RHH_HASH_LAST = 3'd5;

    localparam logic [RHH_ADDR_W-1:0] RHH_REG_MAX_ENTRIES = 3'd0;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_SET    = 2'd1,
        OP_DEL    = 2'd2,
        OP_GETSET = 2'd3
    } rhh_op_t;

    typedef enum logic [2:0] {
        STS_INSERTED  = 3'd0,
        STS_UPDATED   = 3'd1,
        STS_FOUND     = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_FULL      = 3'd4
    } rhh_status_t;

    typedef struct packed {
        rhh_op_t     cmd;
        logic [63:0] key;
        logic [63:0] value;
    } rhh_req_t;

    typedef struct packed {
        rhh_status_t          status;
        logic                 found;
        logic [63:0]          value_res;
        logic [RHH_CNT_W-1:0] entry_count;
    } rhh_rsp_t;

    typedef struct packed {
        logic [63:0] hash;
        logic [63:0] key;
        logic [63:0] value;
    } rhh_entry_t;

    typedef enum logic [3:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_HASH,
        FSM_START,
        FSM_PROBE,
        FSM_PLACE,
        FSM_DEL,
        FSM_RESP
    } rhh_state_t;

    typedef enum logic [1:0] {
        RD_HOME,
        RD_P1,
        RD_P2
    } rhh_rd_sel_t;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_UPDATE,
        WR_SHIFT,
        WR_CARRY
    } rhh_wr_sel_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_HOME,
        IDX_INC
    } rhh_idx_op_t;

    typedef enum logic [1:0] {
        DIST_HOLD,
        DIST_ZERO,
        DIST_INC,
        DIST_SWAP
    } rhh_dist_op_t;

    typedef enum logic [1:0] {
        RV_ZERO,
        RV_SLOT,
        RV_INPUT
    } rhh_rv_sel_t;

    typedef struct packed {
        logic         accept;
        logic         hash_en;
        logic         rd_en;
        rhh_rd_sel_t  rd_sel;
        logic         wr_en;
        rhh_wr_sel_t  wr_sel;
        rhh_idx_op_t  idx_op;
        rhh_dist_op_t dist_op;
        logic         carry_swap;
        logic         res_load;
        rhh_status_t  res_status;
        logic         res_found;
        rhh_rv_sel_t  res_vsel;
        logic         cnt_inc;
        logic         cnt_dec;
        logic         out_load;
    } rhh_cmd_t;

    typedef struct packed {
        rhh_op_t op;
        logic    hash_last;
        logic    hit;
        logic    miss;
        logic    empty;
        logic    poorer;
        logic    del_stop;
        logic    full;
        logic    idx_last;
        logic    out_busy;
    } rhh_stat_t;

endpackage

// File: src/rhh_ctrl.sv
module rhh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rhh_pkg::rhh_stat_t st,
    output rhh_pkg::rhh_cmd_t  cmd
);

    rhh_pkg::rhh_state_t state_reg;
    rhh_pkg::rhh_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rhh_pkg::FSM_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rhh_pkg::FSM_CLEAR:
            begin
                if (st.idx_last)
                begin
                    state_next = rhh_pkg::FSM_IDLE;
                end
            end
            rhh_pkg::FSM_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rhh_pkg::FSM_HASH;
                end
            end
            rhh_pkg::FSM_HASH:
            begin
                if (st.hash_last)
                begin
                    state_next = rhh_pkg::FSM_START;
                end
            end
            rhh_pkg::FSM_START:
            begin
                state_next = rhh_pkg::FSM_PROBE;
            end
            rhh_pkg::FSM_PROBE:
            begin
                if (st.hit)
                begin
                    state_next = (st.op == rhh_pkg::OP_DEL) ? rhh_pkg::FSM_DEL
                                                            : rhh_pkg::FSM_RESP;
                end
                else if (st.miss)
                begin
                    if (st.op == rhh_pkg::OP_GET || st.op == rhh_pkg::OP_DEL || st.full)
                    begin
                        state_next = rhh_pkg::FSM_RESP;
                    end
                    else
                    begin
                        state_next = rhh_pkg::FSM_PLACE;
                    end
                end
            end
            rhh_pkg::FSM_PLACE:
            begin
                if (st.empty)
                begin
                    state_next = rhh_pkg::FSM_RESP;
                end
            end
            rhh_pkg::FSM_DEL:
            begin
                if (st.del_stop)
                begin
                    state_next = rhh_pkg::FSM_RESP;
                end
            end
            rhh_pkg::FSM_RESP:
            begin
                if (!st.out_busy)
                begin
                    state_next = rhh_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = rhh_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = rhh_pkg::RD_P1;
        cmd.wr_sel     = rhh_pkg::WR_ZERO;
        cmd.idx_op     = rhh_pkg::IDX_HOLD;
        cmd.dist_op    = rhh_pkg::DIST_HOLD;
        cmd.res_status = rhh_pkg::STS_NOT_FOUND;
        cmd.res_vsel   = rhh_pkg::RV_ZERO;
        req_ready      = 1'b0;
        unique case (state_reg)
            rhh_pkg::FSM_CLEAR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = rhh_pkg::WR_ZERO;
                cmd.idx_op = rhh_pkg::IDX_INC;
            end
            rhh_pkg::FSM_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            rhh_pkg::FSM_HASH:
            begin
                cmd.hash_en = 1'b1;
            end
            rhh_pkg::FSM_START:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = rhh_pkg::RD_HOME;
                cmd.idx_op  = rhh_pkg::IDX_HOME;
                cmd.dist_op = rhh_pkg::DIST_ZERO;
            end
            rhh_pkg::FSM_PROBE:
            begin
                if (st.hit)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_found  = 1'b1;
                    cmd.res_vsel   = rhh_pkg::RV_SLOT;
                    cmd.res_status = (st.op == rhh_pkg::OP_SET) ? rhh_pkg::STS_UPDATED
                                                                : rhh_pkg::STS_FOUND;
                    if (st.op == rhh_pkg::OP_SET)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = rhh_pkg::WR_UPDATE;
                    end
                    if (st.op == rhh_pkg::OP_DEL)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = rhh_pkg::RD_P1;
                    end
                end
                else if (st.miss)
                begin
                    if (st.op == rhh_pkg::OP_GET || st.op == rhh_pkg::OP_DEL)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = rhh_pkg::STS_NOT_FOUND;
                    end
                    else if (st.full)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = rhh_pkg::STS_FULL;
                    end
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = rhh_pkg::RD_P1;
                    cmd.idx_op  = rhh_pkg::IDX_INC;
                    cmd.dist_op = rhh_pkg::DIST_INC;
                end
            end
            rhh_pkg::FSM_PLACE:
            begin
                if (st.empty)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_sel     = rhh_pkg::WR_CARRY;
                    cmd.cnt_inc    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = rhh_pkg::STS_INSERTED;
                    cmd.res_vsel   = (st.op == rhh_pkg::OP_GETSET) ? rhh_pkg::RV_INPUT
                                                                   : rhh_pkg::RV_ZERO;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = rhh_pkg::RD_P1;
                    cmd.idx_op  = rhh_pkg::IDX_INC;
                    cmd.dist_op = rhh_pkg::DIST_INC;
                    if (st.poorer)
                    begin
                        cmd.wr_en      = 1'b1;
                        cmd.wr_sel     = rhh_pkg::WR_CARRY;
                        cmd.carry_swap = 1'b1;
                        cmd.dist_op    = rhh_pkg::DIST_SWAP;
                    end
                end
            end
            rhh_pkg::FSM_DEL:
            begin
                cmd.wr_en = 1'b1;
                if (st.del_stop)
                begin
                    cmd.wr_sel  = rhh_pkg::WR_ZERO;
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.wr_sel = rhh_pkg::WR_SHIFT;
                    cmd.idx_op = rhh_pkg::IDX_INC;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = rhh_pkg::RD_P2;
                end
            end
            rhh_pkg::FSM_RESP:
            begin
                cmd.out_load = !st.out_busy;
            end
            default:
            begin
                cmd.accept = 1'b0;
            end
        endcase
    end

endmodule

// File: src/rhh_dp.sv
module rhh_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rhh_pkg::rhh_cmd_t             cmd,
    output rhh_pkg::rhh_stat_t            st,
    input  logic [rhh_pkg::RHH_MAX_W-1:0] max_entries,
    input  rhh_pkg::rhh_req_t             req,
    output rhh_pkg::rhh_rsp_t             rsp,
    output logic                          rsp_valid,
    input  logic                          rsp_ready
);

    localparam int IW = rhh_pkg::RHH_IDX_W;

    rhh_pkg::rhh_entry_t mem [rhh_pkg::RHH_SLOTS];
    rhh_pkg::rhh_entry_t rd_q_reg;
    rhh_pkg::rhh_entry_t wr_data;
    logic [IW-1:0]       rd_addr;

    rhh_pkg::rhh_op_t    op_reg;
    logic [63:0]         key_reg;
    logic [63:0]         val_reg;
    logic [63:0]         a_reg;
    logic [63:0]         acc_reg;
    logic [63:0]         acc_next;
    logic [2:0]          phase_reg;
    logic [63:0]         h_reg;
    logic [63:0]         ckey_reg;
    logic [63:0]         cval_reg;
    logic [63:0]         chash_reg;
    logic [IW-1:0]       idx_reg;
    logic [IW-1:0]       dist_reg;
    logic [rhh_pkg::RHH_CNT_W-1:0] count_reg;
    rhh_pkg::rhh_status_t res_status_reg;
    logic                res_found_reg;
    logic [63:0]         res_value_reg;
    rhh_pkg::rhh_rsp_t   rsp_reg;
    logic                rsp_valid_reg;

    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic [63:0]         prod;
    logic [63:0]         sum;
    logic [63:0]         mix1;
    logic [63:0]         mix2;
    logic [63:0]         hash_fin;
    logic [IW-1:0]       rd_hd;
    logic [IW-1:0]       nx_hd;
    logic                empty;
    logic                poorer;
    logic                match;

    // splitmix64 multiplies as three 32x32 partial products each
    always_comb
    begin
        case (phase_reg)
            3'd0:    begin op_a = a_reg[31:0];  op_b = rhh_pkg::RHH_MIX_C1[31:0];  end
            3'd1:    begin op_a = a_reg[31:0];  op_b = rhh_pkg::RHH_MIX_C1[63:32]; end
            3'd2:    begin op_a = a_reg[63:32]; op_b = rhh_pkg::RHH_MIX_C1[31:0];  end
            3'd3:    begin op_a = a_reg[31:0];  op_b = rhh_pkg::RHH_MIX_C2[31:0];  end
            3'd4:    begin op_a = a_reg[31:0];  op_b = rhh_pkg::RHH_MIX_C2[63:32]; end
            3'd5:    begin op_a = a_reg[63:32]; op_b = rhh_pkg::RHH_MIX_C2[31:0];  end
            default: begin op_a = '0;           op_b = '0;                         end
        endcase
    end

    assign prod     = 64'(op_a) * 64'(op_b);
    assign sum      = acc_reg + {prod[31:0], 32'd0};
    assign acc_next = (phase_reg == 3'd0 || phase_reg == 3'd3) ? prod : sum;
    assign mix1     = sum ^ (sum >> 27);
    assign mix2     = sum ^ (sum >> 31);
    assign hash_fin = (mix2 == 64'd0) ? rhh_pkg::RHH_HASH_ONE : mix2;

    assign rd_hd  = idx_reg - rd_q_reg.hash[IW-1:0];
    assign nx_hd  = (idx_reg + IW'(1)) - rd_q_reg.hash[IW-1:0];
    assign empty  = (rd_q_reg.hash == 64'd0);
    assign poorer = (rd_hd < dist_reg);
    assign match  = (rd_q_reg.hash == h_reg) && (rd_q_reg.key == key_reg);

    always_comb
    begin
        st.op        = op_reg;
        st.hash_last = (phase_reg == rhh_pkg::RHH_HASH_LAST);
        st.empty     = empty;
        st.poorer    = poorer;
        st.miss      = empty || poorer;
        st.hit       = !empty && !poorer && match;
        st.del_stop  = empty || (nx_hd == '0);
        st.full      = (count_reg >= {1'b0, max_entries})
                    || (int'(count_reg) >= rhh_pkg::RHH_SLOTS - 1);
        st.idx_last  = (idx_reg == IW'(rhh_pkg::RHH_SLOTS - 1));
        st.out_busy  = rsp_valid_reg && !rsp_ready;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            rhh_pkg::RD_HOME: rd_addr = h_reg[IW-1:0];
            rhh_pkg::RD_P2:   rd_addr = idx_reg + IW'(2);
            default:          rd_addr = idx_reg + IW'(1);
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            rhh_pkg::WR_UPDATE: wr_data = '{hash: rd_q_reg.hash, key: rd_q_reg.key,
                                            value: val_reg};
            rhh_pkg::WR_SHIFT:  wr_data = rd_q_reg;
            rhh_pkg::WR_CARRY:  wr_data = '{hash: chash_reg, key: ckey_reg,
                                            value: cval_reg};
            default:            wr_data = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            idx_reg       <= '0;
            dist_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.hash_en)
            begin
                phase_reg <= (phase_reg == rhh_pkg::RHH_HASH_LAST) ? 3'd0 : phase_reg + 3'd1;
            end
            case (cmd.idx_op)
                rhh_pkg::IDX_HOME: idx_reg <= h_reg[IW-1:0];
                rhh_pkg::IDX_INC:  idx_reg <= idx_reg + IW'(1);
                default:           idx_reg <= idx_reg;
            endcase
            case (cmd.dist_op)
                rhh_pkg::DIST_ZERO: dist_reg <= '0;
                rhh_pkg::DIST_INC:  dist_reg <= dist_reg + IW'(1);
                rhh_pkg::DIST_SWAP: dist_reg <= rd_hd + IW'(1);
                default:            dist_reg <= dist_reg;
            endcase
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + 11'd1;
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - 11'd1;
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= req.cmd;
            key_reg  <= req.key;
            val_reg  <= req.value;
            ckey_reg <= req.key;
            cval_reg <= req.value;
            a_reg    <= req.key ^ (req.key >> 30);
        end
        if (cmd.hash_en)
        begin
            acc_reg <= acc_next;
            if (phase_reg == rhh_pkg::RHH_HASH_MID)
            begin
                a_reg <= mix1;
            end
            if (phase_reg == rhh_pkg::RHH_HASH_LAST)
            begin
                h_reg     <= hash_fin;
                chash_reg <= hash_fin;
            end
        end
        if (cmd.carry_swap)
        begin
            ckey_reg  <= rd_q_reg.key;
            cval_reg  <= rd_q_reg.value;
            chash_reg <= rd_q_reg.hash;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_found_reg  <= cmd.res_found;
            case (cmd.res_vsel)
                rhh_pkg::RV_SLOT:  res_value_reg <= rd_q_reg.value;
                rhh_pkg::RV_INPUT: res_value_reg <= val_reg;
                default:           res_value_reg <= '0;
            endcase
        end
        if (cmd.out_load)
        begin
            rsp_reg <= '{status: res_status_reg, found: res_found_reg,
                         value_res: res_value_reg, entry_count: count_reg};
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.rd_en) |-> (rd_addr != idx_reg))
        else $error("slot read and write collide");

    a_dec_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("delete with no live entry");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= rhh_pkg::RHH_SLOTS - 1)
        else $error("live count above table capacity");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(rsp_valid_reg && !rsp_ready))
        else $error("pending result overwritten");

endmodule

// File: src/robin_hood_hash_table.sv
// Steps: the hash phases, the home read, a read per probed slot, a step per slot walked on
// insert or per shift plus the final write on delete, then the load of the result register.
// Requests: one at a time, the next taken the cycle after the result
// is registered; a stalled result holds the block.
// Reset: async active-low; a clearing pass empties all 1024 slots, with
// no request taken until it ends. max_entries resets to 768.
module robin_hood_hash_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rhh_pkg::RHH_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  rhh_pkg::rhh_req_t              req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output rhh_pkg::rhh_rsp_t              rsp
);

    logic [rhh_pkg::RHH_MAX_W-1:0] max_entries_reg;
    logic                          reg_sel;
    rhh_pkg::rhh_cmd_t             cmd;
    rhh_pkg::rhh_stat_t            st;

    assign pready  = 1'b1;
    assign reg_sel = (paddr == rhh_pkg::RHH_REG_MAX_ENTRIES);
    assign prdata  = reg_sel ? {{(32 - rhh_pkg::RHH_MAX_W){1'b0}}, max_entries_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= rhh_pkg::RHH_MAX_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            max_entries_reg <= pwdata[rhh_pkg::RHH_MAX_W-1:0];
        end
    end

    rhh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    rhh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .max_entries (max_entries_reg),
        .req         (req),
        .rsp         (rsp),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready)
    );

endmodule

// File: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rhh_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [RHH_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  req_valid;
    logic                  req_ready;
    rhh_req_t              req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rhh_rsp_t              rsp;

    robin_hood_hash_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    // shadow table
    logic [63:0]          tbl_key [RHH_SLOTS];
    logic [63:0]          tbl_val [RHH_SLOTS];
    logic [63:0]          tbl_hash[RHH_SLOTS];
    logic [RHH_CNT_W-1:0] tbl_count;
    logic [RHH_MAX_W-1:0] tbl_limit;

    rhh_req_t  pending_reqs[$];
    rhh_rsp_t  expected_rsps[$];
    logic [63:0] key_pool[$];
    int        error_count;
    int        idle_cycles;
    bit        timed_out;
    int        gap_left;
    int        burst_left;
    int        stall_phase;
    bit        hold_off;

    function automatic logic [63:0] mix64(input logic [63:0] x);
        logic [63:0] v;
        v = x ^ (x >> 30);
        v = v * RHH_MIX_C1;
        v = v ^ (v >> 27);
        v = v * RHH_MIX_C2;
        v = v ^ (v >> 31);
        return (v != 0) ? v : RHH_HASH_ONE;
    endfunction

    function automatic int home_gap(input int idx, input logic [63:0] h);
        return (idx - int'(h[RHH_IDX_W-1:0])) & (RHH_SLOTS - 1);
    endfunction

    function automatic void table_insert(input logic [63:0] k, input logic [63:0] v,
                                         input logic [63:0] h);
        int idx;
        int probe_len;
        int sd;
        logic [63:0] tk;
        logic [63:0] tv;
        logic [63:0] th;
        idx       = int'(h[RHH_IDX_W-1:0]);
        probe_len = 0;
        for (int n = 0; n < RHH_SLOTS; n++)
        begin
            if (tbl_hash[idx] == 0)
            begin
                tbl_key[idx]  = k;
                tbl_val[idx]  = v;
                tbl_hash[idx] = h;
                return;
            end
            sd = home_gap(idx, tbl_hash[idx]);
            if (sd < probe_len)
            begin
                tk = tbl_key[idx];
                tv = tbl_val[idx];
                th = tbl_hash[idx];
                tbl_key[idx]  = k;
                tbl_val[idx]  = v;
                tbl_hash[idx] = h;
                k = tk;
                v = tv;
                h = th;
                probe_len = sd;
            end
            idx = (idx + 1) & (RHH_SLOTS - 1);
            probe_len++;
        end
    endfunction

    function automatic void table_remove(input int idx);
        int nx;
        for (int n = 0; n < RHH_SLOTS; n++)
        begin
            nx = (idx + 1) & (RHH_SLOTS - 1);
            if (tbl_hash[nx] == 0 || home_gap(nx, tbl_hash[nx]) == 0)
                break;
            tbl_key[idx]  = tbl_key[nx];
            tbl_val[idx]  = tbl_val[nx];
            tbl_hash[idx] = tbl_hash[nx];
            idx = nx;
        end
        tbl_hash[idx] = 0;
        tbl_key[idx]  = 0;
        tbl_val[idx]  = 0;
        if (tbl_count > 0)
            tbl_count--;
    endfunction

    function automatic rhh_rsp_t apply_request(input rhh_req_t r);
        rhh_rsp_t    o;
        logic [63:0] h;
        int          idx;
        int          probe_len;
        int          pos;
        bit          hit;
        int          lim;
        h         = mix64(r.key);
        idx       = int'(h[RHH_IDX_W-1:0]);
        probe_len = 0;
        hit       = 0;
        pos       = 0;
        for (int n = 0; n < RHH_SLOTS; n++)
        begin
            if (tbl_hash[idx] == 0 || home_gap(idx, tbl_hash[idx]) < probe_len)
                break;
            if (tbl_hash[idx] == h && tbl_key[idx] == r.key)
            begin
                hit = 1;
                pos = idx;
                break;
            end
            idx = (idx + 1) & (RHH_SLOTS - 1);
            probe_len++;
        end
        lim = (int'(tbl_limit) > RHH_SLOTS - 1) ? RHH_SLOTS - 1 : int'(tbl_limit);
        o.value_res = '0;
        o.found     = hit;
        if (hit)
        begin
            o.value_res = tbl_val[pos];
            o.status    = STS_FOUND;
            if (r.cmd == OP_SET)
            begin
                tbl_val[pos] = r.value;
                o.status     = STS_UPDATED;
            end
            else if (r.cmd == OP_DEL)
                table_remove(pos);
        end
        else if (r.cmd == OP_GET || r.cmd == OP_DEL)
            o.status = STS_NOT_FOUND;
        else if (int'(tbl_count) >= lim)
            o.status = STS_FULL;
        else
        begin
            table_insert(r.key, r.value, h);
            tbl_count++;
            o.status = STS_INSERTED;
            if (r.cmd == OP_GETSET)
                o.value_res = r.value;
        end
        o.entry_count = tbl_count;
        return o;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    bit req_fire;
    bit rsp_fire;
    always @(posedge clk)
    begin
        req_fire = rst_n && req_valid && req_ready;
        rsp_fire = rst_n && rsp_valid && rsp_ready;
        if (req_fire)
            expected_rsps.push_back(apply_request(req));
        if (rsp_fire)
        begin
            if (expected_rsps.size() == 0)
            begin
                report("unexpected response", rsp.value_res, 64'd0);
            end
            else
            begin
                rhh_rsp_t e;
                e = expected_rsps.pop_front();
                if (rsp.status !== e.status)
                    report("status", 64'(rsp.status), 64'(e.status));
                if (rsp.found !== e.found)
                    report("found", 64'(rsp.found), 64'(e.found));
                if (rsp.value_res !== e.value_res)
                    report("value_res", rsp.value_res, e.value_res);
                if (rsp.entry_count !== e.entry_count)
                    report("entry_count", 64'(rsp.entry_count), 64'(e.entry_count));
            end
        end
        if (!rst_n || req_fire || rsp_fire)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // driver: bursts and gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 0;
        else if (req_valid && !req_fire)
            ;
        else
        begin
            if (req_fire)
                void'(pending_reqs.pop_front());
            if (pending_reqs.size() == 0 || hold_off)
                req_valid <= 0;
            else if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 0;
            end
            else
            begin
                req_valid <= 1;
                req <= pending_reqs[0];
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        stall_phase = (stall_phase + 1) % 64;
        if (stall_phase < 16)
            rsp_ready <= 1;
        else if (stall_phase < 24)
            rsp_ready <= (stall_phase % 3) != 0;
        else
            rsp_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic apb_write(input logic [RHH_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        tbl_limit = data[RHH_MAX_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return rand64();
    endfunction

    task automatic queue_request(input rhh_op_t op, input logic [63:0] k,
                                 input logic [63:0] v);
        rhh_req_t r;
        r.cmd   = op;
        r.key   = k;
        r.value = v;
        pending_reqs.push_back(r);
        if (key_pool.size() < 300)
            key_pool.push_back(k);
    endtask

    task automatic queue_random(input int n, input int set_weight, input int pool_sz);
        int c;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(0, 9);
            if (pool_sz > 0 && key_pool.size() > pool_sz)
                key_pool.delete(0);
            queue_request(c < set_weight ? OP_SET :
                          rhh_op_t'($urandom_range(0, 3)), pick_key(), rand64());
        end
    endtask

    initial
    begin
        rst_n       = 0;
        psel        = 0;
        penable     = 0;
        pwrite      = 0;
        paddr       = '0;
        pwdata      = '0;
        req_valid   = 0;
        req         = '0;
        rsp_ready   = 0;
        error_count = 0;
        idle_cycles = 0;
        timed_out   = 0;
        gap_left    = 0;
        burst_left  = 0;
        stall_phase = 0;
        hold_off    = 0;
        for (int i = 0; i < RHH_SLOTS; i++)
        begin
            tbl_key[i]  = 0;
            tbl_val[i]  = 0;
            tbl_hash[i] = 0;
        end
        tbl_count = 0;
        tbl_limit = RHH_MAX_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: every command, key and value extremes, misses, update, delete
        queue_request(OP_GET, 64'd0, 64'd0);
        queue_request(OP_DEL, 64'd0, 64'd0);
        queue_request(OP_SET, 64'd0, '1);
        queue_request(OP_SET, '1, 64'd0);
        queue_request(OP_GET, 64'd0, 64'd5);
        queue_request(OP_GETSET, '1, 64'h1234);
        queue_request(OP_SET, '1, 64'hAAAA_5555_AAAA_5555);
        queue_request(OP_GETSET, 64'h8000_0000_0000_0000, 64'h5555_AAAA_5555_AAAA);
        queue_request(OP_GET, 64'h8000_0000_0000_0000, 64'd0);
        queue_request(OP_DEL, '1, 64'd0);
        queue_request(OP_GET, '1, 64'd0);
        queue_request(OP_DEL, 64'd0, 64'd0);
        for (int i = 0; i < 6; i++)
            queue_request(OP_SET, 64'(i + 1), 64'(i));
        for (int i = 0; i < 6; i++)
            queue_request(i[0] ? OP_DEL : OP_GETSET, 64'(i + 1), '1);
        wait_drained();

        // limit of one: full refusals
        apb_write(RHH_REG_MAX_ENTRIES << 2, 32'd1);
        queue_random(60, 5, 0);
        while (pending_reqs.size() > 30)
            @(posedge clk);
        // pause until every expected response has come
        hold_off = 1;
        while (req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        hold_off = 0;
        wait_drained();

        // smallest useful limits, churn near full
        apb_write(RHH_REG_MAX_ENTRIES << 2, 32'd12);
        queue_random(300, 4, 40);
        wait_drained();

        // limit at SLOTS-1, the capacity bound; fill deeply to get long probe chains
        apb_write(RHH_REG_MAX_ENTRIES << 2, 32'd1023);
        queue_random(900, 7, 0);
        wait_drained();
        queue_random(400, 2, 0);
        wait_drained();

        // lower below current count, then reset value
        apb_write(RHH_REG_MAX_ENTRIES << 2, 32'd200);
        queue_random(200, 5, 0);
        wait_drained();
        apb_write(RHH_REG_MAX_ENTRIES << 2, 32'(RHH_MAX_RESET));
        queue_random(200, 3, 0);
        wait_drained();

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
